@@ rtl/core/blid_pkg.sv @@
package blid_pkg;

    localparam int CAPACITY   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int POS_W      = 8;
    localparam int ELEM_W     = 32;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_W-1:0]             count_t;
    typedef logic [IDX_W-1:0]             idx_t;

    typedef enum logic [1:0] {
        ACT_FRONT  = 2'd0,
        ACT_BACK   = 2'd1,
        ACT_DELETE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_LOAD_TAIL,
        CELL_SHIFT_DOWN,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LIST
    } state_t;

    typedef struct packed {
        cell_op_t          op;
        count_t            count;
        logic [POS_W-1:0]  pos;
        value_t            value;
    } cell_ctrl_t;

endpackage

@@ rtl/core/bounded_list_insert_delete.sv @@
// Channel   Handshake            Word
// -------   ------------------   ---------------------------------------
// input     in_valid / in_ready  action, item_value, position
// output    out_valid/out_ready  element, is_last, list_empty, status
//
// Each item is handled as an update followed by a listing of every live word;
// an empty list yields a single word flagged list_empty.
// The listing rotates live cells through cell 0, one word per unstalled cycle.
// Reset empties the list at once; slot contents are not cleared.
// A stalled output holds the rotation; a new item is taken once the last word
// of the listing sits in the output register.
module bounded_list_insert_delete (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   action,
    input  logic signed [31:0]           item_value,
    input  logic [7:0]                   position,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [31:0]           element,
    output logic                         is_last,
    output logic                         list_empty,
    output logic [1:0]                   status
);
    import blid_pkg::*;

    state_t     state_reg, state_next;
    count_t     count_reg, count_next;
    count_t     idx_reg, idx_next;
    status_t    status_reg, status_next;
    logic       out_valid_reg, out_valid_next;
    logic signed [ELEM_W-1:0] element_reg, element_next;
    logic       is_last_reg, is_last_next;
    logic       empty_reg, empty_next;
    status_t    out_status_reg, out_status_next;
    cell_ctrl_t ctrl;
    value_t     cell_data [CAPACITY];
    logic       accept;
    logic       out_free;
    logic       last_word;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            blid_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .idx       (idx_t'(g)),
                .prev_data (cell_data[(g == 0) ? 0 : g - 1]),
                .next_data (cell_data[(g == CAPACITY - 1) ? g : g + 1]),
                .wrap_data (cell_data[0]),
                .data      (cell_data[g])
            );
        end
    endgenerate

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign last_word = (idx_reg == count_reg - count_t'(1));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        element_next    = element_reg;
        is_last_next    = is_last_reg;
        empty_next      = empty_reg;
        out_status_next = out_status_reg;
        ctrl.op         = CELL_HOLD;
        ctrl.count      = count_reg;
        ctrl.pos        = position;
        ctrl.value      = VALUE_BITS'(item_value);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STATUS_DONE;
                    idx_next    = '0;
                    state_next  = ST_LIST;
                    case (action)
                        ACT_FRONT, ACT_BACK:
                        begin
                            if (count_reg == count_t'(CAPACITY))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ctrl.op    = (action == ACT_FRONT) ? CELL_SHIFT_UP
                                                                   : CELL_LOAD_TAIL;
                                count_next = count_reg + count_t'(1);
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (position >= POS_W'(count_reg))
                            begin
                                status_next = STATUS_RANGE;
                            end
                            else
                            begin
                                ctrl.op    = CELL_SHIFT_DOWN;
                                count_next = count_reg - count_t'(1);
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_DONE;
                        end
                    endcase
                end
            end
            ST_LIST:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    if (count_reg == '0)
                    begin
                        element_next = '0;
                        is_last_next = 1'b1;
                        empty_next   = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        element_next = ELEM_W'(cell_data[0]);
                        is_last_next = last_word;
                        empty_next   = 1'b0;
                        ctrl.op      = CELL_ROTATE;
                        idx_next     = idx_reg + count_t'(1);
                        if (last_word)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        element_reg    <= element_next;
        is_last_reg    <= is_last_next;
        empty_reg      <= empty_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign element    = element_reg;
    assign is_last    = is_last_reg;
    assign list_empty = empty_reg;
    assign status     = out_status_reg;

endmodule

@@ rtl/core/blid_cell.sv @@
module blid_cell (
    input  logic                clk,
    input  blid_pkg::cell_ctrl_t ctrl,
    input  blid_pkg::idx_t      idx,
    input  blid_pkg::value_t    prev_data,
    input  blid_pkg::value_t    next_data,
    input  blid_pkg::value_t    wrap_data,
    output blid_pkg::value_t    data
);
    import blid_pkg::*;

    value_t data_reg;
    value_t data_next;
    count_t my_count;

    assign my_count = CNT_W'(idx);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_SHIFT_UP:
            begin
                data_next = (idx == '0) ? ctrl.value : prev_data;
            end
            CELL_LOAD_TAIL:
            begin
                if (my_count == ctrl.count)
                begin
                    data_next = ctrl.value;
                end
            end
            CELL_SHIFT_DOWN:
            begin
                // close the gap: everything at or above the deleted slot moves down
                if (POS_W'(idx) >= ctrl.pos)
                begin
                    data_next = next_data;
                end
            end
            CELL_ROTATE:
            begin
                // the last live cell takes the front word so the list comes back intact
                data_next = (my_count == ctrl.count - count_t'(1)) ? wrap_data : next_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
